@@ rtl/core/sha_pkg.sv @@
package sha_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_t;

  localparam logic FUNC_ABSORB   = 1'b0;
  localparam logic FUNC_FINALIZE = 1'b1;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/sha_queue.sv @@
module sha_queue #(
  parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sha_pkg::in_beat_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output sha_pkg::in_beat_t rd_data,
  output logic             empty
);
  import sha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_beat_t           mem [DEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [AW:0]        count_r;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en && !full)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (rd_en && !empty)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule

@@ rtl/core/sha_core.sv @@
module sha_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sha_pkg::in_beat_t  q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output sha_pkg::out_beat_t out_data
);
  import sha_pkg::*;

  core_state_t  state_r, state_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [5:0]   rnd_r;
  logic [63:0]  msg_bits_r;
  logic         fin_r;
  logic         pad_second_r;
  logic [2:0]   emit_r;

  logic [31:0]  s0, s1, w_new, t1, t2, ea, aa, rnd_k;
  logic         take;
  logic [7:0]   pad_byte [64];

  // round function on the working registers
  always_comb begin
    ea = v_r[4];
    aa = v_r[0];
    t1 = v_r[7] + ({ea[5:0], ea[31:6]} ^ {ea[10:0], ea[31:11]} ^ {ea[24:0], ea[31:25]})
         + ((ea & v_r[5]) ^ (~ea & v_r[6])) + rnd_k + w_r[0];
    t2 = ({aa[1:0], aa[31:2]} ^ {aa[12:0], aa[31:13]} ^ {aa[21:0], aa[31:22]})
         + ((aa & v_r[1]) ^ (aa & v_r[2]) ^ (v_r[1] & v_r[2]));
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
         ^ (w_r[14] >> 10);
    w_new = s1 + w_r[9] + s0 + w_r[0];
  end

  assign rnd_k = round_k(rnd_r);
  assign take  = (state_r == ST_IDLE) && !q_empty;

  // padded block image built from the buffer, a byte per slot
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      pad_byte[i] = w_r[i/4][8*(3-(i%4)) +: 8];
      if (pad_second_r || i > fill_r) pad_byte[i] = 8'h00;
      if (!pad_second_r && i == fill_r) pad_byte[i] = 8'h80;
      if (i >= 56 && (pad_second_r || fill_r < 6'd56))
        pad_byte[i] = msg_bits_r[8*(63-i) +: 8];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_data.func == FUNC_FINALIZE) state_nxt = ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_ROUND;
        end
      end
      ST_PAD:   state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (!pad_second_r && fill_r >= 6'd56) state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (out_pop && emit_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = take;
    out_empty = (state_r != ST_EMIT);
    out_data.digest_word = h_r[emit_r];
    out_data.word_index  = emit_r;
    out_data.last        = (emit_r == 3'd7);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      bits_r       <= '0;
      rnd_r        <= '0;
      fin_r        <= 1'b0;
      pad_second_r <= 1'b0;
      emit_r       <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[32*(7-i) +: 32];
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (take) begin
          rnd_r <= '0;
          if (q_data.func == FUNC_FINALIZE) begin
            fin_r        <= 1'b1;
            pad_second_r <= 1'b0;
          end else begin
            fin_r  <= 1'b0;
            fill_r <= fill_r + 1'b1;
            if (fill_r == 6'd63) bits_r <= bits_r + 64'd512;
          end
        end
        ST_PAD:   rnd_r <= '0;
        ST_ROUND: rnd_r <= rnd_r + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (fin_r) pad_second_r <= 1'b1;
        end
        ST_EMIT: if (out_pop) begin
          emit_r <= emit_r + 1'b1;
          if (emit_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_r[i] <= INIT_HASH[32*(7-i) +: 32];
            fill_r <= '0;
            bits_r <= '0;
            fin_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // message schedule window and working variables
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_data.func == FUNC_FINALIZE)
            msg_bits_r <= bits_r + {55'd0, fill_r, 3'd0};
          else
            w_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= q_data.data_byte;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++)
          w_r[i] <= {pad_byte[4*i], pad_byte[4*i+1], pad_byte[4*i+2], pad_byte[4*i+3]};
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream. An absorb beat adds one byte to the block; the
// 64th byte of a block starts 64 rounds of the single shared round unit,
// followed by the chaining add. A finalize beat pads one or two blocks (block
// load, 64 rounds, add each) and then offers the eight digest words, one per
// pop. Beats queue in a short input buffer of QUEUE_DEPTH entries while the
// round unit is busy.
module sha256_byte_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  sha_pkg::in_beat_t  in_data,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output sha_pkg::out_beat_t out_data
);
  import sha_pkg::*;

  in_beat_t q_data;
  logic     q_empty, q_pop;

  // front: input beat queue
  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_push), .wr_data(in_data), .full(in_full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  // back: buffer, compression and digest output
  sha_core u_core (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );
endmodule

@@ dv/sha256_digest_checker.sv @@
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  sha_pkg::in_beat_t  in_data,
  input  logic               in_full,
  input  logic               out_pop,
  input  logic               out_empty,
  input  sha_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending_words
);
  import sha_pkg::*;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned byte_fill;
  logic [63:0] done_bits;
  out_beat_t   digest_queue [$];

  assign pending_words = digest_queue.size();

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_state
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[255 - 32*i -: 32];
    byte_fill = 0;
    done_bits = '0;
  endtask

  // absorb or pad and queue the eight digest words
  task automatic hash_beat(input in_beat_t b);
    logic [63:0] msg_bits;
    int unsigned pos;
    out_beat_t   o;
    if (b.func == FUNC_ABSORB) begin
      msg_block[byte_fill] = b.data_byte;
      byte_fill++;
      if (byte_fill == 64) begin
        compress();
        done_bits += 64'd512;
        byte_fill = 0;
      end
    end else begin
      msg_bits = done_bits + 64'(byte_fill * 8);
      pos = byte_fill;
      msg_block[pos++] = 8'h80;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_state[i];
        o.word_index  = 3'(i);
        o.last        = (i == 7);
        digest_queue = {digest_queue, o};
      end
      restart_message();
    end
  endtask

  initial begin
    fail_count = 0;
    restart_message();
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      restart_message();
      digest_queue.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (digest_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat %h", out_data);
        end else begin
          want = digest_queue.pop_front();
          if (out_data.digest_word !== want.digest_word ||
              out_data.word_index !== want.word_index ||
              out_data.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected word %h idx %0d last %0b, got %h idx %0d last %0b",
                       want.digest_word, want.word_index, want.last,
                       out_data.digest_word, out_data.word_index, out_data.last);
          end
        end
      end
      if (in_push && !in_full) hash_beat(in_data);
    end
  end

endmodule

@@ dv/tb_sha256_byte_stream_hasher.sv @@
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher;
  import sha_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_beat_t  in_data = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_beat_t out_data;
  int        fail_count;
  int        pending_words;
  bit        hold_results = 1'b0;
  int        quiet_cycles = 0;

  always #10 clk = ~clk;

  sha256_byte_stream_hasher dut (.*);

  sha256_digest_checker chk (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // offer one beat and wait until it is taken
  task automatic send_beat(input logic f, input logic [7:0] b);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    in_push = 1'b1;
    in_data.func = f;
    in_data.data_byte = b;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  task automatic send_message(input int n, input int mode);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_beat(FUNC_ABSORB, b);
    end
    send_beat(FUNC_FINALIZE, 8'($urandom));
  endtask

  task automatic drain_results();
    while (pending_words != 0) @(negedge clk);
  endtask

  // result side: random pops, held off while hold_results is set
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_pop = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_pop = 1'b0;
          repeat (g - 1) @(negedge clk);
        end else begin
          out_pop = 1'b1;
        end
      end
    end
  end

  // long hold-off of the result side, counted in its own process
  initial begin
    wait (rst_n);
    repeat (300) @(negedge clk);
    hold_results = 1'b1;
    repeat (3000) @(negedge clk);
    hold_results = 1'b0;
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // directed: empty, double finalize, short messages, all-ones bytes
    send_beat(FUNC_FINALIZE, 8'hff);
    send_beat(FUNC_FINALIZE, 8'h00);
    send_message(3, 2);
    send_message(1, 1);
    send_message(1, 0);
    send_message(5, 2);
    // many short finalizes while results are held back fill the input queue
    for (int i = 0; i < 6; i++) send_beat(FUNC_FINALIZE, 8'($urandom));
    drain_results();
    send_message(55, 0);
    send_message(56, 1);
    send_message(63, 2);
    send_message(64, 2);
    drain_results();
    repeat (200) @(negedge clk);
    send_message(119, 2);
    // random messages, mostly short
    for (int n = 0; n < 4; n++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 130) : $urandom_range(0, 20);
      send_message(len, 2);
      if ($urandom_range(0, 5) == 0) drain_results();
    end
    drain_results();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sha_pkg.sv
rtl/core/sha_queue.sv
rtl/core/sha_core.sv
rtl/core/sha256_byte_stream_hasher.sv
dv/sha256_digest_checker.sv
dv/tb_sha256_byte_stream_hasher.sv
